// File: design/euler_angle_vector_rotation_assert.svh
// ----------------------------------------------------------------------------
// Euler rotation assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLE_VECTOR_ROTATION_ASSERT_SVH
`define EULER_ANGLE_VECTOR_ROTATION_ASSERT_SVH

// same-cycle implication
`define EAVR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eavr: implication check failed");

// next-cycle implication
`define EAVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eavr: next-cycle check failed");

`endif

// File: design/eavr_pkg.sv
// ----------------------------------------------------------------------------
// Euler rotation package
// Widths, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package eavr_pkg;

    localparam int ANGLE_WIDTH  = 16;
    localparam int VECTOR_WIDTH = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 34;   // CORDIC x/y/z datapath
    localparam int TRIG_W       = 22;   // Q1.20 with room for +1.0
    localparam int ENTRY_W      = 16;   // Q2.14 matrix entry
    localparam int M_ONE        = 16384;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
    };

endpackage

// File: design/eavr_if.sv
// ----------------------------------------------------------------------------
// Euler rotation channels
// Attitude input and result output valid/ready interfaces.
// ----------------------------------------------------------------------------
interface eavr_att_if #(
    parameter int ANGLE_WIDTH  = eavr_pkg::ANGLE_WIDTH,
    parameter int VECTOR_WIDTH = eavr_pkg::VECTOR_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic        [ANGLE_WIDTH-1:0]  roll_angle;
    logic        [ANGLE_WIDTH-1:0]  pitch_angle;
    logic        [ANGLE_WIDTH-1:0]  yaw_angle;
    logic signed [VECTOR_WIDTH-1:0] vec_x;
    logic signed [VECTOR_WIDTH-1:0] vec_y;
    logic signed [VECTOR_WIDTH-1:0] vec_z;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, vec_x, vec_y, vec_z,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, vec_x, vec_y, vec_z,
                    output ready);
endinterface

interface eavr_res_if #(
    parameter int VECTOR_WIDTH = eavr_pkg::VECTOR_WIDTH
);
    logic                                  valid;
    logic                                  ready;
    logic signed [eavr_pkg::ENTRY_W-1:0]   m11, m12, m13, m21, m22, m23, m31, m32, m33;
    logic signed [VECTOR_WIDTH:0]          out_x;
    logic signed [VECTOR_WIDTH:0]          out_y;
    logic signed [VECTOR_WIDTH:0]          out_z;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    out_x, out_y, out_z, input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    out_x, out_y, out_z, output ready);
endinterface

// File: design/eavr_cordic.sv
// ----------------------------------------------------------------------------
// Pipelined CORDIC sine/cosine
// One iteration per stage between an input register and a Q1.20 output register.
// ----------------------------------------------------------------------------
module eavr_cordic #(
    parameter int ANGLE_WIDTH = eavr_pkg::ANGLE_WIDTH
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic        [ANGLE_WIDTH-1:0]       angle,
    output logic signed [eavr_pkg::TRIG_W-1:0]  sin_val,
    output logic signed [eavr_pkg::TRIG_W-1:0]  cos_val
);
    localparam int N  = eavr_pkg::CORDIC_STEPS;
    localparam int XW = eavr_pkg::CORDIC_W;
    localparam int TW = eavr_pkg::TRIG_W;
    localparam logic signed [XW-1:0] T_ONE  = XW'(1) <<< 20;
    localparam logic signed [XW-1:0] T_MONE = -T_ONE;
    localparam logic signed [XW-1:0] HALF   = XW'(512);

    logic signed [XW-1:0] x_reg [0:N];
    logic signed [XW-1:0] y_reg [0:N];
    logic signed [XW-1:0] z_reg [0:N];
    logic                 flip_reg [0:N];
    logic signed [XW-1:0] x_next [0:N-1];
    logic signed [XW-1:0] y_next [0:N-1];
    logic signed [XW-1:0] z_next [0:N-1];

    // fold the angle into the right half plane
    logic [31:0] phase, wrapped, folded;
    always_comb
    begin
        phase   = {angle, {(32-ANGLE_WIDTH){1'b0}}};
        wrapped = phase + 32'h4000_0000;
        folded  = wrapped[31] ? (phase + 32'h8000_0000) : phase;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= eavr_pkg::CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= XW'($signed(folded));
            flip_reg[0] <= wrapped[31];
        end
    end

    // rotation stages
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_comb
        begin
            if (!z_reg[i][XW-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - eavr_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + eavr_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // round to Q1.20, clamp, undo the fold
    logic signed [XW-1:0] xr, yr, xc, yc;
    logic signed [TW-1:0] cos_next, sin_next;
    always_comb
    begin
        xr = (x_reg[N] + HALF) >>> 10;
        yr = (y_reg[N] + HALF) >>> 10;
        xc = (xr > T_ONE) ? T_ONE : ((xr < T_MONE) ? T_MONE : xr);
        yc = (yr > T_ONE) ? T_ONE : ((yr < T_MONE) ? T_MONE : yr);
        cos_next = flip_reg[N] ? -xc[TW-1:0] : xc[TW-1:0];
        sin_next = flip_reg[N] ? -yc[TW-1:0] : yc[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_val <= cos_next;
            sin_val <= sin_next;
        end
    end

endmodule

// File: design/euler_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// Z-X-Y Euler rotation matrix and vector rotation
// Builds the nine Q2.14 entries from roll/pitch/yaw and rotates a vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled. The
// three CORDIC pipelines (one iteration per stage) come first, then the
// forming and rounding of the matrix entries (pair products, split triple
// products, merge, sum, round), then the matrix-vector product. A stalled output
// freezes the whole pipeline; ready drops only while a result waits.
// ----------------------------------------------------------------------------
`include "euler_angle_vector_rotation_assert.svh"

module euler_angle_vector_rotation #(
    parameter int ANGLE_WIDTH  = eavr_pkg::ANGLE_WIDTH,
    parameter int VECTOR_WIDTH = eavr_pkg::VECTOR_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    eavr_att_if.sink    attitude,
    eavr_res_if.source  result
);
    localparam int TW   = eavr_pkg::TRIG_W;
    localparam int EW   = eavr_pkg::ENTRY_W;
    localparam int VW   = VECTOR_WIDTH;
    localparam int PW   = 2 * TW;          // pair product
    localparam int HW   = TW;              // high half of a pair product
    localparam int LW   = PW - HW;         // low half, unsigned
    localparam int SW   = 64;              // Q60 sums
    localparam int MW   = EW + VW;         // entry times component
    localparam int AW2  = VW + 18;         // row accumulator
    localparam int CLAT = eavr_pkg::CORDIC_STEPS + 2;
    localparam int VDLY = CLAT + 5;
    localparam int LAT  = VDLY + 3;

    localparam logic signed [EW-1:0]  E_ONE  = EW'(eavr_pkg::M_ONE);
    localparam logic signed [EW-1:0]  E_MONE = -E_ONE;
    localparam logic signed [AW2-1:0] O_HI   = $signed({{(AW2-VW){1'b0}}, {VW{1'b1}}});
    localparam logic signed [AW2-1:0] O_LO   = -O_HI - AW2'(1);

    // Q60 value to clamped Q2.14 entry
    function automatic logic signed [EW-1:0] to_entry(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) <<< 45)) >>> 46;
        if (r > SW'(eavr_pkg::M_ONE))
            return E_ONE;
        else if (r < -SW'(eavr_pkg::M_ONE))
            return E_MONE;
        else
            return r[EW-1:0];
    endfunction

    // global advance: the pipeline moves unless a result is held
    logic             en;
    logic [LAT-1:0]   vld_reg;
    assign en             = !vld_reg[LAT-1] || result.ready;
    assign attitude.ready = en;
    assign result.valid   = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], attitude.valid};
    end

    // sine and cosine
    logic signed [TW-1:0] sf, cf, st, ct, sp, cp;

    eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
        .clk(clk), .en(en), .angle(attitude.roll_angle), .sin_val(sf), .cos_val(cf));
    eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
        .clk(clk), .en(en), .angle(attitude.pitch_angle), .sin_val(st), .cos_val(ct));
    eavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
        .clk(clk), .en(en), .angle(attitude.yaw_angle), .sin_val(sp), .cos_val(cp));

    // vector delay line
    logic signed [VW-1:0] vx_reg [0:VDLY-1];
    logic signed [VW-1:0] vy_reg [0:VDLY-1];
    logic signed [VW-1:0] vz_reg [0:VDLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= attitude.vec_x;
            vy_reg[0] <= attitude.vec_y;
            vz_reg[0] <= attitude.vec_z;
            for (int k = 1; k < VDLY; k++)
            begin
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
                vz_reg[k] <= vz_reg[k-1];
            end
        end
    end

    // stage B: pair products
    // 0 cp*ct, 1 sf*sp, 2 cf*sp, 3 cp*st, 4 ct*sp, 5 cp*sf, 6 cf*cp, 7 sp*st,
    // 8 cf*st, 9 cf*ct
    logic signed [PW-1:0] pb_reg [0:9];
    logic signed [TW-1:0] sf_b_reg, st_b_reg, ct_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pb_reg[0] <= cp * ct;
            pb_reg[1] <= sf * sp;
            pb_reg[2] <= cf * sp;
            pb_reg[3] <= cp * st;
            pb_reg[4] <= ct * sp;
            pb_reg[5] <= cp * sf;
            pb_reg[6] <= cf * cp;
            pb_reg[7] <= sp * st;
            pb_reg[8] <= cf * st;
            pb_reg[9] <= cf * ct;
            sf_b_reg  <= sf;
            st_b_reg  <= st;
            ct_b_reg  <= ct;
        end
    end

    // stage C: triple products as high and low partial products
    // 0 (sf*sp)*st, 1 (sf*sp)*ct, 2 (cp*sf)*st, 3 (cp*ct)*sf
    logic signed [PW-1:0]   pc_reg [0:9];
    logic signed [HW+TW-1:0] qh_reg [0:3];
    logic signed [LW+TW:0]   ql_reg [0:3];
    logic signed [TW-1:0]   sf_c_reg;
    logic signed [PW-1:0]   tp [0:3];
    logic signed [TW-1:0]   tm [0:3];

    always_comb
    begin
        tp[0] = pb_reg[1]; tm[0] = st_b_reg;
        tp[1] = pb_reg[1]; tm[1] = ct_b_reg;
        tp[2] = pb_reg[5]; tm[2] = st_b_reg;
        tp[3] = pb_reg[0]; tm[3] = sf_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                qh_reg[k] <= $signed(tp[k][PW-1:LW]) * tm[k];
                ql_reg[k] <= $signed({1'b0, tp[k][LW-1:0]}) * tm[k];
            end
            pc_reg   <= pb_reg;
            sf_c_reg <= sf_b_reg;
        end
    end

    // stage D: merge partial products
    logic signed [SW-1:0] t_reg [0:3];
    logic signed [PW-1:0] pd_reg [0:9];
    logic signed [TW-1:0] sf_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                t_reg[k] <= (SW'(qh_reg[k]) <<< LW) + SW'(ql_reg[k]);
            pd_reg   <= pc_reg;
            sf_d_reg <= sf_c_reg;
        end
    end

    // stage E: Q60 entry sums (slot 7 unused here, m32 comes from sf)
    logic signed [SW-1:0] e_reg [0:8];
    logic signed [TW-1:0] sf_e_reg;
    logic signed [SW-1:0] bq [0:9];

    always_comb
    begin
        for (int k = 0; k < 10; k++)
            bq[k] = SW'(pd_reg[k]) <<< 20;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= bq[0] - t_reg[0];
            e_reg[1] <= -bq[2];
            e_reg[2] <= bq[3] + t_reg[1];
            e_reg[3] <= bq[4] + t_reg[2];
            e_reg[4] <= bq[6];
            e_reg[5] <= bq[7] - t_reg[3];
            e_reg[6] <= -bq[8];
            e_reg[7] <= '0;
            e_reg[8] <= bq[9];
            sf_e_reg <= sf_d_reg;
        end
    end

    // stage F: round entries to Q2.14
    logic signed [EW-1:0] ent_reg [0:8];
    logic signed [TW-1:0] m32_r;
    logic signed [EW-1:0] m32_next;

    always_comb
    begin
        m32_r = (sf_e_reg + TW'(32)) >>> 6;
        if (m32_r > TW'(eavr_pkg::M_ONE))
            m32_next = E_ONE;
        else if (m32_r < -TW'(eavr_pkg::M_ONE))
            m32_next = E_MONE;
        else
            m32_next = m32_r[EW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
                ent_reg[k] <= (k == 7) ? m32_next : to_entry(e_reg[k]);
        end
    end

    // stage G: entry times component
    logic signed [MW-1:0] mv_reg [0:8];
    logic signed [EW-1:0] ent_g_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mv_reg[3*r]   <= ent_reg[3*r]   * vx_reg[VDLY-1];
                mv_reg[3*r+1] <= ent_reg[3*r+1] * vy_reg[VDLY-1];
                mv_reg[3*r+2] <= ent_reg[3*r+2] * vz_reg[VDLY-1];
            end
            ent_g_reg <= ent_reg;
        end
    end

    // stage H: row sums
    logic signed [AW2-1:0] acc_reg [0:2];
    logic signed [EW-1:0]  ent_h_reg [0:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= AW2'(mv_reg[3*r]) + AW2'(mv_reg[3*r+1]) + AW2'(mv_reg[3*r+2]);
            ent_h_reg <= ent_g_reg;
        end
    end

    // stage I: round, saturate, output register
    logic signed [AW2-1:0] rs [0:2];
    logic signed [AW2-1:0] sat [0:2];
    logic signed [EW-1:0]  m_out_reg [0:8];
    logic signed [VW:0]    o_reg [0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rs[r]  = (acc_reg[r] + $signed({{(AW2-14){1'b0}}, 1'b1, 13'd0})) >>> 14;
            sat[r] = (rs[r] > O_HI) ? O_HI : ((rs[r] < O_LO) ? O_LO : rs[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_out_reg <= ent_h_reg;
            for (int r = 0; r < 3; r++)
                o_reg[r] <= sat[r][VW:0];
        end
    end

    assign result.m11   = m_out_reg[0];
    assign result.m12   = m_out_reg[1];
    assign result.m13   = m_out_reg[2];
    assign result.m21   = m_out_reg[3];
    assign result.m22   = m_out_reg[4];
    assign result.m23   = m_out_reg[5];
    assign result.m31   = m_out_reg[6];
    assign result.m32   = m_out_reg[7];
    assign result.m33   = m_out_reg[8];
    assign result.out_x = o_reg[0];
    assign result.out_y = o_reg[1];
    assign result.out_z = o_reg[2];

    // checks
    `EAVR_ASSERT_IMPL(a_stall_only_on_held, clk, rst_n, !attitude.ready, result.valid)
    `EAVR_ASSERT_IMPL(a_m11_range, clk, rst_n, result.valid,
        (result.m11 <= E_ONE) && (result.m11 >= E_MONE))
    `EAVR_ASSERT_IMPL(a_m22_range, clk, rst_n, result.valid,
        (result.m22 <= E_ONE) && (result.m22 >= E_MONE))
    `EAVR_ASSERT_NEXT(a_held_stays, clk, rst_n, result.valid && !result.ready,
        result.valid && $stable(result.out_x))

endmodule
